>>> design/lsp_pkg.sv
package lsp_pkg;

    // Default stack depth in words
    localparam int STACK_DEPTH_DEF = 8;

    // Word width of a stack entry
    localparam int WORD_W = 32;

    // Input command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PAL  = 2'd2;
    localparam logic [1:0] CMD_DUMP = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    // Kind of result beat the datapath loads into its output register
    localparam logic [2:0] EMIT_PUSH_OK  = 3'd0;
    localparam logic [2:0] EMIT_OVERFLOW = 3'd1;
    localparam logic [2:0] EMIT_EMPTY    = 3'd2;
    localparam logic [2:0] EMIT_POP      = 3'd3;
    localparam logic [2:0] EMIT_PAL_TRUE = 3'd4;
    localparam logic [2:0] EMIT_PAL_FALSE = 3'd5;
    localparam logic [2:0] EMIT_DUMP     = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic       do_push;    // write value on top, count up
        logic       rd_top;     // read top word, count down
        logic       pal_init;   // low pointer to bottom, high pointer to top
        logic       pal_step;   // move both pointers inward
        logic       dump_init;  // walk pointer to top
        logic       dump_step;  // walk pointer down one
        logic       emit;       // load a result beat
        logic [2:0] emit_kind;
    } lsp_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic ptrs_met;   // low pointer at or past high pointer
        logic rd_match;   // both read words equal
        logic ptr_zero;   // walk pointer at bottom entry
    } lsp_stat_t;

endpackage

>>> design/lifo_stack_with_palindrome_check.sv
// Channel   Handshake                    Payload
// -------   --------------------------   -------------------------------------------
// command   start / busy                 cmd, value
// result    result_strobe (one cycle)    status, data, position, is_palindrome,
//                                        depth_now, last
//
// A command beat is taken when start is high and busy is low; each result beat
// shows for one cycle, starting the cycle after the edge that produced it.
// Push: a push may follow every cycle. Pop: registered RAM read.
// Palindrome: compares word pairs from both ends (two RAM read ports) and ends at
// the first pair that differs; dump: one beat per entry.
// Pop, palindrome or dump on an empty stack is answered from idle.
// Reset (rst_n low, async) empties the stack; store contents are not cleared.
// The receiver cannot stall; a beat is lost if not taken in its cycle.
module lifo_stack_with_palindrome_check #(
    parameter int STACK_DEPTH = lsp_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    output logic               result_strobe,
    output logic [1:0]         status,
    output logic signed [31:0] data,
    output logic [2:0]         position,
    output logic               is_palindrome,
    output logic [3:0]         depth_now,
    output logic               last
);

    lsp_pkg::lsp_ctl_t  ctl;
    lsp_pkg::lsp_stat_t stat;

    lsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .ctl   (ctl),
        .stat  (stat)
    );

    lsp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .ctl           (ctl),
        .stat          (stat),
        .result_strobe (result_strobe),
        .status        (status),
        .data          (data),
        .position      (position),
        .is_palindrome (is_palindrome),
        .depth_now     (depth_now),
        .last          (last)
    );

    // Push onto a full stack reports overflow in the next cycle
    a_push_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == lsp_pkg::CMD_PUSH && stat.full)
        |=> (result_strobe && status == lsp_pkg::ST_OVERFLOW && last))
        else $error("push on full stack did not report overflow");

    // Pop of a non-empty stack stays busy with no beat in S_POP, then delivers its word
    a_pop_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == lsp_pkg::CMD_POP && !stat.empty)
        |=> (busy && !result_strobe) ##1 (result_strobe && status == lsp_pkg::ST_OK))
        else $error("pop result missing or late");

    // A non-final beat only comes from a dump still in progress
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |-> busy)
        else $error("non-final result beat with controller idle");

    // The store is never written past its top
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.do_push |-> !stat.full)
        else $error("write to full stack");

endmodule

>>> design/lsp_ram.sv
module lsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                        rdata_a,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                        rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> design/lsp_ctrl.sv
module lsp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    output logic              busy,
    output lsp_pkg::lsp_ctl_t ctl,
    input  lsp_pkg::lsp_stat_t stat
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_POP      = 3'd1;
    localparam logic [2:0] S_PAL_RD   = 3'd2;
    localparam logic [2:0] S_PAL_CMP  = 3'd3;
    localparam logic [2:0] S_DUMP_RD  = 3'd4;
    localparam logic [2:0] S_DUMP_OUT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        lsp_pkg::CMD_PUSH:
                        begin
                            ctl.emit = 1'b1;
                            if (stat.full)
                            begin
                                ctl.emit_kind = lsp_pkg::EMIT_OVERFLOW;
                            end
                            else
                            begin
                                ctl.do_push   = 1'b1;
                                ctl.emit_kind = lsp_pkg::EMIT_PUSH_OK;
                            end
                        end
                        lsp_pkg::CMD_POP:
                        begin
                            if (stat.empty)
                            begin
                                ctl.emit      = 1'b1;
                                ctl.emit_kind = lsp_pkg::EMIT_EMPTY;
                            end
                            else
                            begin
                                ctl.rd_top = 1'b1;
                                state_next = S_POP;
                            end
                        end
                        lsp_pkg::CMD_PAL:
                        begin
                            if (stat.empty)
                            begin
                                ctl.emit      = 1'b1;
                                ctl.emit_kind = lsp_pkg::EMIT_PAL_TRUE;
                            end
                            else
                            begin
                                ctl.pal_init = 1'b1;
                                state_next   = S_PAL_RD;
                            end
                        end
                        lsp_pkg::CMD_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                ctl.emit      = 1'b1;
                                ctl.emit_kind = lsp_pkg::EMIT_EMPTY;
                            end
                            else
                            begin
                                ctl.dump_init = 1'b1;
                                state_next    = S_DUMP_RD;
                            end
                        end
                    endcase
                end
            end
            S_POP:
            begin
                ctl.emit      = 1'b1;
                ctl.emit_kind = lsp_pkg::EMIT_POP;
                state_next    = S_IDLE;
            end
            // pointers address the RAM here; words arrive in S_PAL_CMP
            S_PAL_RD:
            begin
                if (stat.ptrs_met)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = lsp_pkg::EMIT_PAL_TRUE;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_PAL_CMP;
                end
            end
            S_PAL_CMP:
            begin
                if (!stat.rd_match)
                begin
                    ctl.emit      = 1'b1;
                    ctl.emit_kind = lsp_pkg::EMIT_PAL_FALSE;
                    state_next    = S_IDLE;
                end
                else
                begin
                    ctl.pal_step = 1'b1;
                    state_next   = S_PAL_RD;
                end
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                ctl.emit      = 1'b1;
                ctl.emit_kind = lsp_pkg::EMIT_DUMP;
                if (stat.ptr_zero)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.dump_step = 1'b1;
                    state_next    = S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/lsp_dpath.sv
module lsp_dpath #(
    parameter int STACK_DEPTH = lsp_pkg::STACK_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [31:0]        value,
    input  lsp_pkg::lsp_ctl_t         ctl,
    output lsp_pkg::lsp_stat_t        stat,
    output logic                      result_strobe,
    output logic [1:0]                status,
    output logic signed [31:0]        data,
    output logic [2:0]                position,
    output logic                      is_palindrome,
    output logic [3:0]                depth_now,
    output logic                      last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] ptr_a_reg;
    logic [AW-1:0] ptr_a_next;
    logic [AW-1:0] ptr_b_reg;
    logic [AW-1:0] ptr_b_next;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] raddr_a;
    logic [31:0]   rd_a;
    logic [31:0]   rd_b;
    logic [31:0]   cnt_ext;
    logic [31:0]   pos_ext;

    logic          strobe_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic [31:0]   data_reg;
    logic [31:0]   data_next;
    logic [2:0]    position_reg;
    logic [2:0]    position_next;
    logic          pal_reg;
    logic          pal_next;
    logic [3:0]    depth_reg;
    logic          last_reg;
    logic          last_next;

    assign count_m1 = count_reg - CW'(1);
    assign top_addr = count_m1[AW-1:0];

    // Entry count and walk pointers
    always_comb
    begin
        count_next = count_reg;
        if (ctl.do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.rd_top)
        begin
            count_next = count_m1;
        end

        ptr_a_next = ptr_a_reg;
        ptr_b_next = ptr_b_reg;
        priority if (ctl.pal_init)
        begin
            ptr_a_next = '0;
            ptr_b_next = top_addr;
        end
        else if (ctl.dump_init)
        begin
            ptr_a_next = top_addr;
        end
        else if (ctl.pal_step)
        begin
            ptr_a_next = ptr_a_reg + AW'(1);
            ptr_b_next = ptr_b_reg - AW'(1);
        end
        else if (ctl.dump_step)
        begin
            ptr_a_next = ptr_a_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_a_reg <= ptr_a_next;
        ptr_b_reg <= ptr_b_next;
    end

    // Stack store
    assign raddr_a = ctl.rd_top ? top_addr : ptr_a_reg;

    lsp_ram #(
        .WIDTH (lsp_pkg::WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ctl.do_push),
        .waddr   (count_reg[AW-1:0]),
        .wdata   (value),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (ptr_b_reg),
        .rdata_b (rd_b)
    );

    // Status to controller
    assign stat.full     = (count_reg == FULL_COUNT);
    assign stat.empty    = (count_reg == '0);
    assign stat.ptrs_met = (ptr_a_reg >= ptr_b_reg);
    assign stat.rd_match = (rd_a == rd_b);
    assign stat.ptr_zero = (ptr_a_reg == '0);

    // Result beat fields
    assign cnt_ext = 32'(count_next);
    assign pos_ext = 32'(ptr_a_reg);

    always_comb
    begin
        status_next   = lsp_pkg::ST_OK;
        data_next     = '0;
        position_next = '0;
        pal_next      = 1'b0;
        last_next     = 1'b1;
        unique case (ctl.emit_kind)
            lsp_pkg::EMIT_PUSH_OK:
            begin
            end
            lsp_pkg::EMIT_OVERFLOW:
            begin
                status_next = lsp_pkg::ST_OVERFLOW;
            end
            lsp_pkg::EMIT_EMPTY:
            begin
                status_next = lsp_pkg::ST_EMPTY;
            end
            lsp_pkg::EMIT_POP:
            begin
                data_next = rd_a;
            end
            lsp_pkg::EMIT_PAL_TRUE:
            begin
                pal_next = 1'b1;
            end
            lsp_pkg::EMIT_PAL_FALSE:
            begin
            end
            lsp_pkg::EMIT_DUMP:
            begin
                data_next     = rd_a;
                position_next = pos_ext[2:0];
                last_next     = stat.ptr_zero;
            end
            default:
            begin
            end
        endcase
    end

    // Output register: strobe is control, the rest payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            status_reg   <= status_next;
            data_reg     <= data_next;
            position_reg <= position_next;
            pal_reg      <= pal_next;
            depth_reg    <= cnt_ext[3:0];
            last_reg     <= last_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign data          = $signed(data_reg);
    assign position      = position_reg;
    assign is_palindrome = pal_reg;
    assign depth_now     = depth_reg;
    assign last          = last_reg;

endmodule
